// ----- hw/rtl/wdfc_pkg.sv -----
`default_nettype none

package wdfc_pkg;

    // frame layout
    localparam int unsigned SEED_BITS    = 7;
    localparam int unsigned SERVICE_BITS = 16;

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] GOOD_RESIDUE = 32'h2144_DF1C;

    // one finished psdu byte on its way from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic [11:0] idx;
        logic        last;
    } t_byte_entry;

    // one byte through the reflected crc, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int n = 0; n < 8; n++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wdfc_bit_if.sv -----
`default_nettype none

interface wdfc_bit_if;
    logic        valid;
    logic        ready;
    logic        first_bit;
    logic        data_bit;
    logic [11:0] psdu_len;

    modport source (output valid, first_bit, data_bit, psdu_len, input ready);
    modport sink   (input valid, first_bit, data_bit, psdu_len, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wdfc_byte_if.sv -----
`default_nettype none

interface wdfc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [11:0] byte_index;
    logic        last_byte;
    logic        fcs_ok;

    modport source (output valid, out_byte, byte_index, last_byte, fcs_ok, input ready);
    modport sink   (input valid, out_byte, byte_index, last_byte, fcs_ok, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/wlan_descrambler_fcs_check.sv -----
`default_nettype none

// channel   | dir | payload                                   | handshake
// ----------+-----+-------------------------------------------+-------------
// i_bit     | in  | first_bit, data_bit, psdu_len[11:0]       | valid/ready
// o_byte    | out | out_byte[7:0], byte_index[11:0],          | valid/ready
//           |     | last_byte, fcs_ok                         |
//
// one decoded bit per cycle while i_bit.ready is high; a psdu byte is queued
// at its 8th bit, and its crc step runs in the back end while it is registered.
// i_bit.ready drops only when the byte queue (QUEUE_DEPTH entries) is full.
// synchronous active-low reset clears the frame state, queue and output valid.
// a stalled output holds its transaction; the front end keeps taking bits
// until the queue fills.

module wlan_descrambler_fcs_check #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    wdfc_bit_if.sink    i_bit,
    wdfc_byte_if.source o_byte
);

    logic                  q_full;
    logic                  push;
    wdfc_pkg::t_byte_entry push_entry;
    logic                  q_valid;
    wdfc_pkg::t_byte_entry q_entry;
    logic                  pop;

    // descrambler and byte gathering
    wdfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bit    (i_bit),
        .i_q_full (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // byte queue between the two ends
    wdfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    // crc check and output register
    wdfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_byte    (o_byte)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/wdfc_front.sv -----
`default_nettype none

module wdfc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    wdfc_bit_if.sink             i_bit,
    input  wire                  i_q_full,
    output logic                 o_push,
    output wdfc_pkg::t_byte_entry o_entry
);

    logic        r_active;
    logic [15:0] r_pos;
    logic [6:0]  r_scr;
    logic [7:0]  r_gather;
    logic [11:0] r_len;

    logic        n_active;
    logic [15:0] n_pos;
    logic [6:0]  n_scr;
    logic [7:0]  n_gather;
    logic [11:0] n_len;

    logic        accept;
    logic        e_active;
    logic [15:0] e_pos;
    logic [6:0]  e_scr;
    logic [7:0]  e_gather;
    logic [11:0] e_len;
    logic [15:0] total;
    logic [15:0] pos_inc;
    logic [2:0]  sub;
    logic        fb;
    logic        dbit;

    // a new bit is taken whenever the queue has room
    assign i_bit.ready = !i_q_full;
    assign accept      = i_bit.valid && i_bit.ready;

    // a first bit restarts the frame state before the bit is worked
    always_comb begin
        if (i_bit.first_bit) begin
            e_active = 1'b1;
            e_pos    = '0;
            e_scr    = '0;
            e_gather = '0;
            e_len    = i_bit.psdu_len;
        end else begin
            e_active = r_active;
            e_pos    = r_pos;
            e_scr    = r_scr;
            e_gather = r_gather;
            e_len    = r_len;
        end
    end

    assign total   = {1'b0, e_len, 3'b000} + 16'(wdfc_pkg::SERVICE_BITS);
    assign pos_inc = e_pos + 16'd1;
    assign sub     = e_pos[2:0];
    assign fb      = e_scr[6] ^ e_scr[3];
    assign dbit    = fb ^ i_bit.data_bit;

    // seed, descramble, gather and byte push
    always_comb begin
        n_active = r_active;
        n_pos    = r_pos;
        n_scr    = r_scr;
        n_gather = r_gather;
        n_len    = r_len;
        o_push   = 1'b0;
        o_entry.data = e_gather;
        o_entry.idx  = 12'(e_pos[15:3] - 13'd2);
        o_entry.last = (pos_inc == total);
        if (accept && e_active) begin
            n_len    = e_len;
            n_gather = e_gather;
            if (e_pos < 16'(wdfc_pkg::SEED_BITS)) begin
                n_scr = e_scr | ({6'd0, i_bit.data_bit} << (3'd6 - sub));
            end else begin
                n_scr = {e_scr[5:0], fb};
                if (sub == 3'd0) begin
                    n_gather = {7'd0, dbit};
                end else begin
                    n_gather = e_gather | ({7'd0, dbit} << sub);
                end
                o_push = (sub == 3'd7) && (e_pos >= 16'(wdfc_pkg::SERVICE_BITS));
            end
            o_entry.data = n_gather;
            n_pos    = pos_inc;
            n_active = (pos_inc < total);
        end else if (accept) begin
            // idle bit with no frame running
            n_active = 1'b0;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_scr    <= '0;
            r_gather <= '0;
            r_len    <= '0;
        end else begin
            r_active <= n_active;
            r_pos    <= n_pos;
            r_scr    <= n_scr;
            r_gather <= n_gather;
            r_len    <= n_len;
        end
    end

    // the last byte of a frame always closes it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_entry.last) |=> !r_active)
        else $error("frame still active after its last byte");

endmodule

`default_nettype wire

// ----- hw/rtl/wdfc_queue.sv -----
`default_nettype none

module wdfc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wdfc_pkg::t_byte_entry i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output wdfc_pkg::t_byte_entry o_entry,
    input  wire                   i_pop
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    wdfc_pkg::t_byte_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill level beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("byte pushed into a full queue");

endmodule

`default_nettype wire

// ----- hw/rtl/wdfc_back.sv -----
`default_nettype none

module wdfc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_valid,
    input  wdfc_pkg::t_byte_entry i_q_entry,
    output logic                  o_pop,
    wdfc_byte_if.source           o_byte
);

    logic [31:0] r_crc;
    logic        r_valid;
    logic [7:0]  r_data;
    logic [11:0] r_idx;
    logic        r_last;
    logic        r_fcs_ok;

    logic [31:0] crc_in;
    logic [31:0] crc_new;

    // the first byte of a frame starts from the crc seed
    assign crc_in  = (i_q_entry.idx == 12'd0) ? wdfc_pkg::CRC_INIT : r_crc;
    assign crc_new = wdfc_pkg::crc_byte(crc_in, i_q_entry.data);
    assign o_pop   = i_q_valid && (!r_valid || o_byte.ready);

    // output transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_crc   <= wdfc_pkg::CRC_INIT;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_crc   <= crc_new;
        end else if (o_byte.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data   <= i_q_entry.data;
            r_idx    <= i_q_entry.idx;
            r_last   <= i_q_entry.last;
            r_fcs_ok <= i_q_entry.last
                        && ((crc_new ^ wdfc_pkg::CRC_INIT) == wdfc_pkg::GOOD_RESIDUE);
        end
    end

    assign o_byte.valid      = r_valid;
    assign o_byte.out_byte   = r_data;
    assign o_byte.byte_index = r_idx;
    assign o_byte.last_byte  = r_last;
    assign o_byte.fcs_ok     = r_fcs_ok;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last) |-> !r_fcs_ok)
        else $error("fcs flag set on a byte that is not the last");

endmodule

`default_nettype wire
